@@ src/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants and GF(2^8) helper functions for the AES block.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUNDS    = 10;
    localparam int KEY_WORDS = 4;
    localparam int RK_WORDS  = 4 * (ROUNDS + 1);
    localparam int RK_AW     = $clog2(RK_WORDS);
    localparam int CFG_AW    = 3;

    localparam logic [CFG_AW-1:0] REG_KEY_HIGH  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_KEY_LOW   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_IV_HIGH   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_IV_LOW    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DIRECTION = 3'd4;
    localparam logic [CFG_AW-1:0] REG_CHAINING  = 3'd5;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        message_start;
    } in_word_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXPAND, ST_LOADKEY, ST_INIT, ST_ROUND, ST_DONE
    } state_t;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic last;
        logic decrypt;
    } rnd_ctrl_t;

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] v);
        logic [7:0] t [256];
        t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[v];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] t [256];
        t = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[v];
    endfunction

endpackage

@@ src/aes_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ src/aes_round.sv @@
// ----------------------------------------------------------------------------
// AES round unit
// Holds the 128-bit state and applies one full round per step, forward or
// inverse, with the round key supplied by the caller.
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; (
    input  logic         aclk,
    input  rnd_ctrl_t    ctrl,
    input  logic [127:0] load_data,
    input  logic [127:0] round_key,
    output logic [127:0] state
);
    logic [127:0] state_reg, state_next;
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   m [16];
    logic [127:0] rnd_out;

    // Byte i of the block sits in bits 127-8i.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_reg[127-8*i -: 8];
        end
        // Forward: sub then shift. Inverse: shift then sub.
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (ctrl.decrypt) begin
                    t[4*c+r] = inv_sbox(s[4*((c-r+4)%4)+r]);
                end else begin
                    t[4*c+r] = sbox(s[4*((c+r)%4)+r]);
                end
            end
        end
        // Forward: mix then key. Inverse: key then inverse mix.
        for (int i = 0; i < 16; i++) begin
            m[i] = ctrl.decrypt ? (t[i] ^ round_key[127-8*i -: 8]) : t[i];
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
            logic [7:0] x0, x1, x2, x3, y0, y1, y2, y3;
            a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
            b0 = xt(a0); b1 = xt(a1); b2 = xt(a2); b3 = xt(a3);
            y0 = xt(b0); y1 = xt(b1); y2 = xt(b2); y3 = xt(b3);
            x0 = xt(y0); x1 = xt(y1); x2 = xt(y2); x3 = xt(y3);
            if (ctrl.last) begin
                rnd_out[127-32*c -: 32] = {m[4*c], m[4*c+1], m[4*c+2], m[4*c+3]};
            end else if (ctrl.decrypt) begin
                // 0e = x8^x4^x2, 0b = x8^x2^1, 0d = x8^x4^1, 09 = x8^1
                rnd_out[127-32*c -: 32] = {
                    (x0^y0^b0)^(x1^b1^a1)^(x2^y2^a2)^(x3^a3),
                    (x0^a0)^(x1^y1^b1)^(x2^b2^a2)^(x3^y3^a3),
                    (x0^y0^a0)^(x1^a1)^(x2^y2^b2)^(x3^b3^a3),
                    (x0^b0^a0)^(x1^y1^a1)^(x2^a2)^(x3^y3^b3)};
            end else begin
                rnd_out[127-32*c -: 32] = {
                    b0^(b1^a1)^a2^a3,
                    a0^b1^(b2^a2)^a3,
                    a0^a1^b2^(b3^a3),
                    (b0^a0)^a1^a2^b3};
            end
        end
        if (!ctrl.decrypt) begin
            rnd_out = rnd_out ^ round_key;
        end
    end

    // State register update.
    always_comb begin
        state_next = state_reg;
        priority if (ctrl.load) begin
            state_next = load_data;
        end else if (ctrl.init) begin
            state_next = state_reg ^ round_key;
        end else if (ctrl.step) begin
            state_next = rnd_out;
        end else begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
    end

    assign state = state_reg;
endmodule

@@ src/aes_keyexp.sv @@
// ----------------------------------------------------------------------------
// AES key expansion
// Produces one round-key word per cycle into the round-key RAM.
// ----------------------------------------------------------------------------
module aes_keyexp import aes_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [127:0]     key,
    output logic             busy,
    output logic             wr_en,
    output logic [RK_AW-1:0] wr_addr,
    output logic [31:0]      wr_data
);
    logic [RK_AW-1:0] idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic [127:0]     win_reg, win_next;
    logic [7:0]       rc_reg, rc_next;
    logic [31:0]      t, w;

    // Sliding window holds the last four words; new word from the oldest and the newest.
    always_comb begin
        t = win_reg[31:0];
        if (idx_reg[1:0] == 2'd0) begin
            t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])}
                ^ {rc_reg, 24'd0};
        end
        w = (idx_reg < RK_AW'(KEY_WORDS)) ? key[127-32*idx_reg[1:0] -: 32]
                                          : (win_reg[127:96] ^ t);
    end

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        win_next  = win_reg;
        rc_next   = rc_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = '0;
            rc_next   = 8'h01;
        end else if (busy_reg) begin
            win_next = {win_reg[95:0], w};
            if (idx_reg >= RK_AW'(KEY_WORDS) && idx_reg[1:0] == 2'd0) begin
                rc_next = xt(rc_reg);
            end
            if (idx_reg == RK_AW'(RK_WORDS - 1)) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        win_reg <= win_next;
        rc_reg  <= rc_next;
    end

    assign busy    = busy_reg;
    assign wr_en   = busy_reg;
    assign wr_addr = idx_reg;
    assign wr_data = w;
endmodule

@@ src/aes128_block_cipher_cbc.sv @@
// ----------------------------------------------------------------------------
// AES-128 block cipher, ECB or CBC
// Top level: configuration, chaining, sequencer and round-key storage.
// ----------------------------------------------------------------------------
// Each word carries one 128-bit block and returns one 128-bit result. One
// round unit is shared by all rounds, and the round key is gathered one
// 32-bit word at a time through the single registered read port of the
// round-key RAM, which sets the pace: for each of the eleven key additions
// the sequencer reads the four words of its key in ST_LOADKEY and then
// applies it in ST_INIT or with its round in ST_ROUND. The result reaches the
// output register from ST_DONE, and the input is ready again in the same
// cycle, so a new block is taken only after the previous one is finished.
// After reset or a key write the first block also waits for the key
// expansion. A finished block waits in its last state while an earlier
// result is still held in the output register.
// ----------------------------------------------------------------------------
module aes128_block_cipher_cbc import aes_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data
);
    logic [127:0] key_reg, iv_reg, chain_reg, chain_next, in_reg;
    logic         dir_reg, cbc_reg, keys_ready_reg, keys_ready_next;
    state_t       state_reg, state_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [2:0]   wsel_reg, wsel_next;
    logic [127:0] rk_reg, rk_next;
    logic         ke_start, ke_busy, ke_we;
    logic [RK_AW-1:0] ke_addr, rd_addr;
    logic [31:0]  ke_data, rd_data;
    rnd_ctrl_t    ctrl;
    logic [127:0] st, load_data, res;
    logic         out_valid_reg, out_valid_next;
    logic [127:0] out_reg, out_next;
    logic [3:0]   key_rnd;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            iv_reg  <= '0;
            dir_reg <= 1'b0;
            cbc_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_HIGH:  key_reg[127:64] <= cfg_data;
                REG_KEY_LOW:   key_reg[63:0]   <= cfg_data;
                REG_IV_HIGH:   iv_reg[127:64]  <= cfg_data;
                REG_IV_LOW:    iv_reg[63:0]    <= cfg_data;
                REG_DIRECTION: dir_reg         <= cfg_data[0];
                REG_CHAINING:  cbc_reg         <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aes_keyexp u_keyexp (
        .aclk(aclk), .aresetn(aresetn), .start(ke_start), .key(key_reg),
        .busy(ke_busy), .wr_en(ke_we), .wr_addr(ke_addr), .wr_data(ke_data)
    );

    aes_ram #(.WIDTH(32), .DEPTH(RK_WORDS)) u_rk_ram (
        .aclk(aclk), .wr_en(ke_we), .wr_addr(ke_addr), .wr_data(ke_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Round key index used by the upcoming operation.
    assign key_rnd = dir_reg ? 4'(ROUNDS) - rnd_reg : rnd_reg;
    assign rd_addr = RK_AW'({key_rnd, 2'b00}) + RK_AW'(wsel_reg[1:0]);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = keys_ready_reg ? ST_LOADKEY : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (!ke_busy && keys_ready_reg) begin
                    state_next = ST_LOADKEY;
                end
            end
            ST_LOADKEY: begin
                if (wsel_reg == 3'd4) begin
                    state_next = (rnd_reg == 4'd0) ? ST_INIT : ST_ROUND;
                end
            end
            ST_INIT:  state_next = ST_LOADKEY;
            ST_ROUND: state_next = (rnd_reg == 4'(ROUNDS)) ? ST_DONE : ST_LOADKEY;
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath control.
    always_comb begin
        ctrl         = '0;
        ctrl.decrypt = dir_reg;
        ctrl.last    = (rnd_reg == 4'(ROUNDS));
        ke_start     = 1'b0;
        keys_ready_next = keys_ready_reg;
        rnd_next     = rnd_reg;
        wsel_next    = wsel_reg;
        rk_next      = rk_reg;
        chain_next   = chain_reg;
        out_next     = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (state_reg == ST_IDLE && s_valid && s_ready) begin
            ctrl.load = 1'b1;
            rnd_next  = '0;
            wsel_next = '0;
            if (s_data.message_start) begin
                chain_next = iv_reg;
            end
            if (!keys_ready_reg) begin
                ke_start        = 1'b1;
                keys_ready_next = 1'b1;
            end
        end
        if (state_reg == ST_LOADKEY) begin
            // RAM read data is registered and lags its address.
            if (wsel_reg != 3'd0) begin
                rk_next = {rk_reg[95:0], rd_data};
            end
            wsel_next = wsel_reg + 1'b1;
        end
        if (state_reg == ST_INIT) begin
            ctrl.init = 1'b1;
            rnd_next  = 4'd1;
            wsel_next = '0;
        end
        // The counter stops at the last round.
        if (state_reg == ST_ROUND) begin
            ctrl.step = 1'b1;
            if (rnd_reg != 4'(ROUNDS)) begin
                rnd_next = rnd_reg + 1'b1;
            end
            wsel_next = '0;
        end
        if (state_reg == ST_DONE && (!out_valid_reg || m_ready)) begin
            out_next       = res;
            out_valid_next = 1'b1;
            if (cbc_reg) begin
                chain_next = dir_reg ? in_reg : res;
            end
        end
        if (cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW)) begin
            keys_ready_next = 1'b0;
        end
    end

    // Input whitening for CBC encryption, output XOR for CBC decryption; chain message start taken now.
    always_comb begin
        logic [127:0] ch;
        ch = s_data.message_start ? iv_reg : chain_reg;
        load_data = {s_data.block_high, s_data.block_low};
        if (cbc_reg && !dir_reg) begin
            load_data = load_data ^ ch;
        end
        res = (cbc_reg && dir_reg) ? (st ^ chain_reg) : st;
    end

    aes_round u_round (
        .aclk(aclk), .ctrl(ctrl), .load_data(load_data),
        .round_key(rk_reg), .state(st)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = {out_reg[127:64], out_reg[63:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            chain_reg      <= '0;
            rnd_reg        <= '0;
            wsel_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            keys_ready_reg <= keys_ready_next;
            out_valid_reg  <= out_valid_next;
            chain_reg      <= chain_next;
            rnd_reg        <= rnd_next;
            wsel_reg       <= wsel_next;
        end
        rk_reg  <= rk_next;
        out_reg <= out_next;
        if (state_reg == ST_IDLE && s_valid && s_ready) begin
            in_reg <= {s_data.block_high, s_data.block_low};
        end
    end

    // A result is never overwritten while it waits.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result overwritten while stalled");
    // No block is taken while the key is still being expanded.
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        ke_busy |-> !s_ready)
        else $error("input taken during key expansion");
    // The round counter never runs past the last round.
    a_rnd: assert property (@(posedge aclk) disable iff (!aresetn)
        rnd_reg <= 4'(ROUNDS))
        else $error("round counter out of range");
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 ECB/CBC block cipher testbench
// Drives 128-bit blocks through the cipher under several key, IV, direction
// and chaining settings, predicts every result with an independent AES model
// and compares each output word field by field, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module testbench;
    import aes_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_index;
    logic [63:0]       cfg_data;
    logic              s_valid;
    logic              s_ready;
    in_word_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_word_t         m_data;

    aes128_block_cipher_cbc u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Predictor state: its own copy of the registers and the chain.
    logic [63:0] pr_key_high, pr_key_low, pr_iv_high, pr_iv_low;
    logic        pr_decrypt, pr_cbc;
    logic [63:0] pr_chain_high, pr_chain_low;
    logic [31:0] pr_rkw [RK_WORDS];

    out_word_t   cipher_results [$];
    int          mismatch_count = 0;
    int          words_checked = 0;
    int          cycle_count = 0;
    int          known_errors;
    int          s_idle_pct, m_idle_pct;
    logic [7:0]  fbox [256];
    logic [7:0]  ibox [256];

    localparam int CYCLE_LIMIT = 2000000;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Substitution tables built from the GF(2^8) inverse and affine map.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    task automatic build_boxes();
        logic [7:0] inv, x;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h00;
            for (int w = 1; w < 256; w++)
                if (gf_mul(v[7:0], w[7:0]) == 8'h01) inv = w[7:0];
            x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fbox[v] = x;
            ibox[x] = v[7:0];
        end
    endtask

    task automatic expand_round_keys();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        pr_rkw[0] = pr_key_high[63:32];
        pr_rkw[1] = pr_key_high[31:0];
        pr_rkw[2] = pr_key_low[63:32];
        pr_rkw[3] = pr_key_low[31:0];
        for (int i = KEY_WORDS; i < RK_WORDS; i++) begin
            t = pr_rkw[i-1];
            if (i % KEY_WORDS == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fbox[t[31:24]] ^ rc, fbox[t[23:16]], fbox[t[15:8]], fbox[t[7:0]]};
                rc = gf_mul(rc, 8'h02);
            end
            pr_rkw[i] = pr_rkw[i-KEY_WORDS] ^ t;
        end
    endtask

    // The state is kept as the 128-bit block; byte b sits at bits 127-8b.
    function automatic logic [127:0] add_round_key(input logic [127:0] s, input int rnd);
        return s ^ {pr_rkw[4*rnd], pr_rkw[4*rnd+1], pr_rkw[4*rnd+2], pr_rkw[4*rnd+3]};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input int rnd,
                                               input logic inverse, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
        if (!inverse) begin
            for (int i = 0; i < 16; i++) b[i] = fbox[b[i]];
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++) t[4*c+w] = b[4*((c+w)%4)+w];
            if (!last)
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    t[4*c]   = gf_mul(a0, 8'd2) ^ gf_mul(a1, 8'd3) ^ a2 ^ a3;
                    t[4*c+1] = a0 ^ gf_mul(a1, 8'd2) ^ gf_mul(a2, 8'd3) ^ a3;
                    t[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'd2) ^ gf_mul(a3, 8'd3);
                    t[4*c+3] = gf_mul(a0, 8'd3) ^ a1 ^ a2 ^ gf_mul(a3, 8'd2);
                end
            for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
            r = add_round_key(r, rnd);
        end else begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++) t[4*c+w] = ibox[b[4*((c-w+4)%4)+w]];
            for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
            r = add_round_key(r, rnd);
            if (!last) begin
                for (int i = 0; i < 16; i++) t[i] = r[127-8*i -: 8];
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    t[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^
                               gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
                    t[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^
                               gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
                    t[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^
                               gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
                    t[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^
                               gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
                end
                for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
            end
        end
        return r;
    endfunction

    // Works out the result of one accepted word and advances the chain.
    function automatic out_word_t predict_cipher(input in_word_t w);
        logic [127:0] blk, s, chain;
        out_word_t    res;
        if (w.message_start) begin
            pr_chain_high = pr_iv_high;
            pr_chain_low  = pr_iv_low;
        end
        chain = {pr_chain_high, pr_chain_low};
        blk = {w.block_high, w.block_low};
        if (!pr_decrypt) begin
            s = pr_cbc ? (blk ^ chain) : blk;
            s = add_round_key(s, 0);
            for (int r = 1; r <= ROUNDS; r++) s = aes_round(s, r, 1'b0, r == ROUNDS);
            if (pr_cbc) {pr_chain_high, pr_chain_low} = s;
        end else begin
            s = add_round_key(blk, ROUNDS);
            for (int r = ROUNDS - 1; r >= 0; r--) s = aes_round(s, r, 1'b1, r == 0);
            if (pr_cbc) begin
                s = s ^ chain;
                {pr_chain_high, pr_chain_low} = blk;
            end
        end
        {res.result_high, res.result_low} = s;
        return res;
    endfunction

    // One register write, mirrored in the predictor; the enable drops for a cycle.
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_KEY_HIGH:  pr_key_high = val;
            REG_KEY_LOW:   pr_key_low = val;
            REG_IV_HIGH:   pr_iv_high = val;
            REG_IV_LOW:    pr_iv_low = val;
            REG_DIRECTION: pr_decrypt = val[0];
            REG_CHAINING:  pr_cbc = val[0];
            default: ;
        endcase
        if (idx == REG_KEY_HIGH || idx == REG_KEY_LOW) expand_round_keys();
        @(posedge aclk);
    endtask

    task automatic setup_cipher(input logic [63:0] kh, input logic [63:0] kl,
                                input logic [63:0] ih, input logic [63:0] il,
                                input logic dec, input logic cbc);
        write_reg(REG_KEY_HIGH, kh);
        write_reg(REG_KEY_LOW, kl);
        write_reg(REG_IV_HIGH, ih);
        write_reg(REG_IV_LOW, il);
        write_reg(REG_DIRECTION, {$urandom, $urandom} & ~64'h1 | 64'(dec));
        write_reg(REG_CHAINING, {$urandom, $urandom} & ~64'h1 | 64'(cbc));
    endtask

    // Sends one word, with an optional random gap first. Valid stays high after
    // acceptance so that back-to-back words need no second assignment; a gap or
    // the drain drops it.
    task automatic send_block(input in_word_t w);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        cipher_results = {cipher_results, predict_cipher(w)};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (cipher_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic in_word_t rand_block(input logic start);
        in_word_t w;
        w.block_high = {$urandom, $urandom};
        w.block_low  = {$urandom, $urandom};
        w.message_start = start;
        return w;
    endfunction

    // Receiver: random stalls and the comparison against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (cipher_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result word %h_%h", m_data.result_high,
                             m_data.result_low);
            end else begin
                out_word_t exp_w;
                exp_w = cipher_results.pop_front();
                words_checked++;
                if (exp_w.result_high !== m_data.result_high ||
                    exp_w.result_low !== m_data.result_low) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %h_%h, got %h_%h",
                                 exp_w.result_high, exp_w.result_low,
                                 m_data.result_high, m_data.result_low);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Directed rows: rows marked known carry a standard result vector.
    typedef struct {
        logic [63:0] kh, kl, bh, bl;
        logic        dec, cbc, start, known;
        logic [63:0] rh, rl;
    } block_row_t;

    block_row_t dir_rows [] = '{
        '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0011223344556677,
          64'h8899aabbccddeeff, 1'b0, 1'b0, 1'b0, 1'b1,
          64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
        '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h69c4e0d86a7b0430,
          64'hd8cdb78070b4c55a, 1'b1, 1'b0, 1'b1, 1'b1,
          64'h0011223344556677, 64'h8899aabbccddeeff},
        '{64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0, 1'b0, 1'b1,
          64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 64'hffffffffffffffff,
          64'hffffffffffffffff, 1'b0, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 64'h0, 64'h0,
          1'b1, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{64'h0, 64'hffffffffffffffff, 64'h8000000000000000, 64'h1,
          1'b1, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0}
    };

    initial begin
        out_word_t known_res;
        int        n_sent;
        int        msg_left;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        known_errors = 0;
        s_idle_pct = 0;
        m_idle_pct = 0;
        build_boxes();
        pr_key_high = '0; pr_key_low = '0; pr_iv_high = '0; pr_iv_low = '0;
        pr_decrypt = 1'b0; pr_cbc = 1'b1;
        pr_chain_high = '0; pr_chain_low = '0;
        expand_round_keys();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: CBC encrypt, zero key, zero chain.
        send_block(rand_block(1'b0));
        send_block(rand_block(1'b0));
        drain_results();

        // Directed table; the fixed known results are checked against the predictor too.
        foreach (dir_rows[i]) begin
            setup_cipher(dir_rows[i].kh, dir_rows[i].kl, 64'hffffffffffffffff,
                         64'h0123456789abcdef, dir_rows[i].dec, dir_rows[i].cbc);
            send_block('{block_high: dir_rows[i].bh, block_low: dir_rows[i].bl,
                         message_start: dir_rows[i].start});
            known_res = cipher_results[$];
            if (dir_rows[i].known && (known_res.result_high !== dir_rows[i].rh ||
                                      known_res.result_low !== dir_rows[i].rl)) begin
                known_errors++;
                $display("Predictor disagrees with known vector in row %0d", i);
            end
            send_block(rand_block(1'b0));
            drain_results();
        end

        // IV write without message start leaves the chain alone; unknown index ignored.
        write_reg(REG_IV_HIGH, {$urandom, $urandom});
        write_reg(3'd7, {$urandom, $urandom});
        send_block(rand_block(1'b0));
        send_block(rand_block(1'b1));
        drain_results();

        // Random phases: three idling mixes, one new setting per phase.
        n_sent = 0;
        for (int ph = 0; ph < 12; ph++) begin
            s_idle_pct = (ph < 4) ? 36 : (ph < 8) ? 73 : 0;
            m_idle_pct = (ph < 4) ? 73 : (ph < 8) ? 36 : 0;
            if ($urandom_range(1))
                setup_cipher({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom},
                             ph[0], ph[1] | ph[2]);
            else begin
                write_reg(REG_DIRECTION, 64'(ph[0]));
                write_reg(REG_CHAINING, 64'(ph[1] | ph[2]));
                write_reg(REG_IV_LOW, {$urandom, $urandom});
            end
            msg_left = 0;
            for (int k = 0; k < 108; k++) begin
                if (msg_left == 0) begin
                    msg_left = $urandom_range(12, 1);
                    send_block(rand_block($urandom_range(9) != 0));
                end else
                    send_block(rand_block($urandom_range(19) == 0));
                msg_left--;
                n_sent++;
            end
            drain_results();
        end

        $display("Checked %0d result words over %0d random blocks", words_checked, n_sent);
        $display("Covered ECB and CBC, both directions, key and IV changes, idle mixes");
        if (mismatch_count == 0 && known_errors == 0 && cipher_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
